### sv/srbl_pkg.sv
// ----------------------------------------------------------------------------
// srbl_pkg
// Shared types, sizes and serial-number compares for the SACK block list.
// ----------------------------------------------------------------------------
package srbl_pkg;

	localparam int MAX_BLOCKS = 4;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
	} edge_pair_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		logic start;
		logic visit;
	} merge_ctrl_t;

	function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic seq_leq(input logic [31:0] a, input logic [31:0] b);
		return (a == b) || seq_lt(a, b);
	endfunction

endpackage

### sv/srbl_cell.sv
// ----------------------------------------------------------------------------
// srbl_cell
// One slot of the block list: holds a pair of edges, takes its neighbour's
// pair when the row rotates, or a new pair when the list is rebuilt.
// ----------------------------------------------------------------------------
module srbl_cell
	import srbl_pkg::*;
(
	input  logic       clk,
	input  cell_op_t   op,
	input  edge_pair_t nbr,
	input  edge_pair_t load_val,
	output edge_pair_t held
);

	edge_pair_t pair_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_SHIFT: pair_q <= nbr;
			CELL_LOAD:  pair_q <= load_val;
			default:    pair_q <= pair_q;
		endcase
	end

	assign held = pair_q;

endmodule

### sv/srbl_merge.sv
// ----------------------------------------------------------------------------
// srbl_merge
// Merge unit at the head of the row: grows the new range by every block that
// overlaps or touches it, and flags blocks that are to be kept.
// ----------------------------------------------------------------------------
module srbl_merge
	import srbl_pkg::*;
(
	input  logic        clk,
	input  merge_ctrl_t ctrl,
	input  logic [31:0] new_left,
	input  logic [31:0] new_right,
	input  logic [31:0] next_expected,
	input  edge_pair_t  visited,
	output logic        keep,
	output logic        head,
	output edge_pair_t  merged
);

	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [31:0] nxt_q;
	logic        drop;
	logic        touch;

	assign drop  = seq_leq(visited.right, visited.left) || seq_leq(visited.left, nxt_q);
	assign touch = seq_leq(lo_q, visited.right) && seq_leq(visited.left, hi_q);
	assign keep  = ctrl.visit && !drop && !touch;
	assign head  = seq_lt(nxt_q, lo_q);

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			lo_q  <= new_left;
			hi_q  <= new_right;
			nxt_q <= next_expected;
		end else if (ctrl.visit && !drop && touch) begin
			if (seq_lt(visited.left, lo_q)) begin
				lo_q <= visited.left;
			end
			if (seq_lt(hi_q, visited.right)) begin
				hi_q <= visited.right;
			end
		end
	end

	assign merged.left  = lo_q;
	assign merged.right = hi_q;

endmodule

### sv/sack_receive_block_list.sv
// ----------------------------------------------------------------------------
// sack_receive_block_list
// Receiver SACK block list, most recent first, kept in a rotating row of cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | into      | in_valid / in_stall   | func, new_left, new_right, next_expected
//  out     | out of    | out_valid / out_stall | entry_valid .. last_of_run
//
//  an update passes the scan and commit states before the first result beat: the
//  row rotates once per cycle past the merge unit, then the list is rebuilt
//  clear items and reversed or empty ranges go straight to the result beats
//  one result beat per held block (or one when empty), each held under out_stall
//  in_stall is high from acceptance until the last result beat is taken
//  reset empties the list
// ----------------------------------------------------------------------------
module sack_receive_block_list
	import srbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] new_left,
	input  logic [31:0] new_right,
	input  logic [31:0] next_expected,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        entry_valid,
	output logic [2:0]  entry_index,
	output logic [31:0] block_left,
	output logic [31:0] block_right,
	output logic [3:0]  block_total,
	output logic        range_error,
	output logic        last_of_run
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] k_q;
	logic             err_q;
	edge_pair_t       keep_q [MAX_BLOCKS];

	edge_pair_t  cell_val [MAX_BLOCKS];
	cell_op_t    cell_op;
	merge_ctrl_t mctrl;
	logic        in_beat;
	logic        out_beat;
	logic        m_keep;
	logic        m_head;
	edge_pair_t  m_pair;
	logic [CNT_W-1:0] kept_trim;
	logic        is_last;
	edge_pair_t  shown;

	assign in_stall = (state_q != ST_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign out_valid = (state_q == ST_EMIT);
	assign out_beat  = out_valid && !out_stall;

	assign mctrl.start = in_beat;
	assign mctrl.visit = (state_q == ST_SCAN) && (CNT_W'(step_q) < count_q);

	always_comb begin
		unique case (state_q)
			ST_SCAN:   cell_op = CELL_SHIFT;
			ST_COMMIT: cell_op = CELL_LOAD;
			default:   cell_op = CELL_HOLD;
		endcase
	end

	// row rotates towards slot 0; slot 0 feeds the merge unit
	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		edge_pair_t load_val;
		if (i == 0) begin : g_first
			assign load_val = m_head ? m_pair : keep_q[0];
		end else begin : g_rest
			assign load_val = m_head ? keep_q[i-1] : keep_q[i];
		end
		srbl_cell u_cell (
			.clk      (clk),
			.op       (cell_op),
			.nbr      (cell_val[(i + 1) % MAX_BLOCKS]),
			.load_val (load_val),
			.held     (cell_val[i])
		);
	end

	srbl_merge u_merge (
		.clk           (clk),
		.ctrl          (mctrl),
		.new_left      (new_left),
		.new_right     (new_right),
		.next_expected (next_expected),
		.visited       (cell_val[0]),
		.keep          (m_keep),
		.head          (m_head),
		.merged        (m_pair)
	);

	// on overflow the oldest kept block falls off
	assign kept_trim = (kept_q >= CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS - 1) : kept_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			kept_q  <= '0;
			count_q <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						step_q <= '0;
						kept_q <= '0;
						k_q    <= '0;
						if (func == FUNC_CLEAR) begin
							count_q <= '0;
							err_q   <= 1'b0;
							state_q <= ST_EMIT;
						end else if (!seq_lt(new_left, new_right)) begin
							err_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							err_q   <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (m_keep) begin
						kept_q <= kept_q + CNT_W'(1);
					end
					step_q <= step_q + IDX_W'(1);
					if (step_q == IDX_W'(MAX_BLOCKS - 1)) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					count_q <= m_head ? kept_trim + CNT_W'(1) : kept_q;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_beat) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && m_keep) begin
			keep_q[kept_q[IDX_W-1:0]] <= cell_val[0];
		end
	end

	assign is_last = (count_q == '0) || ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
	assign shown   = cell_val[k_q];

	assign entry_valid = (count_q != '0);
	assign entry_index = entry_valid ? 3'(k_q) : 3'd0;
	assign block_left  = entry_valid ? shown.left : 32'd0;
	assign block_right = entry_valid ? shown.right : 32'd0;
	assign block_total = 4'(count_q);
	assign range_error = err_q;
	assign last_of_run = is_last;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the receiver SACK block list. A queue of segment
// updates and clears drives the input channel with random gaps, while a
// monitor compares every list beat against a software copy of the list.
// ----------------------------------------------------------------------------
module tb;
	import srbl_pkg::*;

	localparam int ITEMS_RANDOM   = 360;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 250;
	localparam int HOLD_AT_ITEM   = 120;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic        f;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] nxt;
	} seg_item_t;

	typedef struct packed {
		logic        ev;
		logic [2:0]  idx;
		logic [31:0] l;
		logic [31:0] r;
		logic [3:0]  tot;
		logic        err;
		logic        last;
	} list_beat_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic        func          = FUNC_ADD;
	logic [31:0] new_left      = '0;
	logic [31:0] new_right     = '0;
	logic [31:0] next_expected = '0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic        entry_valid;
	logic [2:0]  entry_index;
	logic [31:0] block_left;
	logic [31:0] block_right;
	logic [3:0]  block_total;
	logic        range_error;
	logic        last_of_run;

	sack_receive_block_list uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.new_left      (new_left),
		.new_right     (new_right),
		.next_expected (next_expected),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.entry_valid   (entry_valid),
		.entry_index   (entry_index),
		.block_left    (block_left),
		.block_right   (block_right),
		.block_total   (block_total),
		.range_error   (range_error),
		.last_of_run   (last_of_run)
	);

	always #10 clk = ~clk;

	seg_item_t  pending_segs[$];
	list_beat_t want_beats[$];
	seg_item_t  cur_seg;

	// software copy of the list
	logic [31:0] sack_left[MAX_BLOCKS];
	logic [31:0] sack_right[MAX_BLOCKS];
	int          sack_held = 0;

	int items_taken  = 0;
	int beats_seen   = 0;
	int err_count    = 0;
	int n_clears     = 0;
	int n_bad_ranges = 0;
	int n_full       = 0;
	int hold_left    = 0;
	bit hold_done    = 1'b0;
	int idle_cycles  = 0;

	wire calm     = (items_taken >= 200) && (items_taken < 280);
	wire hold_off = (hold_left != 0);

	initial begin
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			sack_left[k]  = '0;
			sack_right[k] = '0;
		end
	end

	function automatic logic sn_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic sn_le(input logic [31:0] a, input logic [31:0] b);
		return (a == b) || sn_lt(a, b);
	endfunction

	task automatic note_mismatch(input string msg);
		err_count++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			note_mismatch($sformatf("beat %0d %s want %0h got %0h", beats_seen, name,
				want, got));
	endtask

	// fold one accepted item into the list and queue the beats it yields
	task automatic sack_list_apply(input seg_item_t it);
		logic [31:0] kl[MAX_BLOCKS];
		logic [31:0] kr[MAX_BLOCKS];
		logic [31:0] lo, hi, s, e;
		int          kept, head;
		logic        err;
		list_beat_t  b;
		err  = 1'b0;
		kept = 0;
		head = 0;
		lo   = it.lo;
		hi   = it.hi;
		if (it.f == FUNC_CLEAR) begin
			for (int k = 0; k < MAX_BLOCKS; k++) begin
				sack_left[k]  = '0;
				sack_right[k] = '0;
			end
			sack_held = 0;
			n_clears++;
		end else if (!sn_lt(it.lo, it.hi)) begin
			err = 1'b1;
			n_bad_ranges++;
		end else begin
			for (int k = 0; k < sack_held; k++) begin
				s = sack_left[k];
				e = sack_right[k];
				if (sn_le(e, s) || sn_le(s, it.nxt)) begin
					// stale or empty, dropped
				end else if (sn_le(lo, e) && sn_le(s, hi)) begin
					if (sn_lt(s, lo))
						lo = s;
					if (sn_lt(hi, e))
						hi = e;
				end else begin
					kl[kept] = s;
					kr[kept] = e;
					kept++;
				end
			end
			if (sn_lt(it.nxt, lo)) begin
				sack_left[0]  = lo;
				sack_right[0] = hi;
				head = 1;
				if (kept >= MAX_BLOCKS)
					kept--;
			end
			for (int k = 0; k < kept; k++) begin
				sack_left[head + k]  = kl[k];
				sack_right[head + k] = kr[k];
			end
			sack_held = head + kept;
		end
		if (sack_held == MAX_BLOCKS)
			n_full++;
		if (sack_held == 0) begin
			b     = '0;
			b.err = err;
			b.last = 1'b1;
			want_beats.push_back(b);
		end else begin
			for (int k = 0; k < sack_held; k++) begin
				b.ev   = 1'b1;
				b.idx  = 3'(k);
				b.l    = sack_left[k];
				b.r    = sack_right[k];
				b.tot  = 4'(sack_held);
				b.err  = err;
				b.last = (k + 1 == sack_held);
				want_beats.push_back(b);
			end
		end
	endtask

	task automatic queue_seg(input logic f, input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] nxt);
		seg_item_t it;
		it.f   = f;
		it.lo  = lo;
		it.hi  = hi;
		it.nxt = nxt;
		pending_segs.push_back(it);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		seg_item_t nx;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			func          <= FUNC_ADD;
			new_left      <= '0;
			new_right     <= '0;
			next_expected <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				sack_list_apply(cur_seg);
				items_taken <= items_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_segs.size() != 0 && (calm || $urandom_range(99) >= 31)) begin
					nx            = pending_segs.pop_front();
					cur_seg       = nx;
					in_valid      <= 1'b1;
					func          <= nx.f;
					new_left      <= nx.lo;
					new_right     <= nx.hi;
					next_expected <= nx.nxt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		list_beat_t w;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (want_beats.size() == 0) begin
					note_mismatch($sformatf("beat %0d with nothing expected", beats_seen));
				end else begin
					w = want_beats.pop_front();
					check_field("entry_valid", 32'(w.ev), 32'(entry_valid));
					check_field("entry_index", 32'(w.idx), 32'(entry_index));
					check_field("block_left", w.l, block_left);
					check_field("block_right", w.r, block_right);
					check_field("block_total", 32'(w.tot), 32'(block_total));
					check_field("range_error", 32'(w.err), 32'(range_error));
					check_field("last_of_run", 32'(w.last), 32'(last_of_run));
				end
				beats_seen++;
			end
			out_stall <= hold_off || (!calm && $urandom_range(99) < 31);
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", idle_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] nxt;
		logic [31:0] lo;
		int          r;
		int          i;

		// directed: merges, overflow, stale blocks, bad ranges, wrap, clears
		queue_seg(FUNC_CLEAR, 32'd0, 32'd0, 32'd0);
		queue_seg(FUNC_ADD, 32'd100, 32'd200, 32'd50);
		queue_seg(FUNC_ADD, 32'd200, 32'd100, 32'd50);
		queue_seg(FUNC_ADD, 32'd150, 32'd150, 32'd50);
		queue_seg(FUNC_ADD, 32'd300, 32'd400, 32'd50);
		queue_seg(FUNC_ADD, 32'd200, 32'd300, 32'd50);
		queue_seg(FUNC_ADD, 32'd500, 32'd600, 32'd50);
		queue_seg(FUNC_ADD, 32'd700, 32'd800, 32'd50);
		queue_seg(FUNC_ADD, 32'd900, 32'd1000, 32'd50);
		queue_seg(FUNC_ADD, 32'd1100, 32'd1200, 32'd50);
		queue_seg(FUNC_ADD, 32'd1300, 32'd1400, 32'd50);
		queue_seg(FUNC_ADD, 32'd1500, 32'd1600, 32'd850);
		// merged range at or below next expected is not stored
		queue_seg(FUNC_ADD, 32'd10, 32'd20, 32'd1000);
		// half-circle range, then it drops out as an empty block
		queue_seg(FUNC_ADD, 32'd0, 32'h8000_0000, 32'hF000_0000);
		queue_seg(FUNC_ADD, 32'd5, 32'd6, 32'd0);
		queue_seg(FUNC_ADD, 32'hFFFF_FF00, 32'h0000_0100, 32'hFFFF_0000);
		queue_seg(FUNC_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE);
		queue_seg(FUNC_ADD, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		queue_seg(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_seg(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_seg(FUNC_ADD, 32'h0000_1000, 32'h0000_2000, 32'h0000_2000);
		queue_seg(FUNC_ADD, 32'h0000_2001, 32'h0000_3000, 32'h0000_2000);

		// random: mostly segments near the receive point, some noise and clears
		nxt = $urandom;
		for (i = 0; i < ITEMS_RANDOM; i++) begin
			if (i % 60 == 0)
				nxt = $urandom;
			r = $urandom_range(99);
			if (r < 8) begin
				queue_seg(FUNC_CLEAR, $urandom, $urandom, $urandom);
			end else if (r < 14) begin
				queue_seg(FUNC_ADD, $urandom, $urandom, $urandom);
			end else if (r < 20) begin
				lo = nxt + $urandom_range(1, 3000);
				queue_seg(FUNC_ADD, lo, lo - $urandom_range(0, 400), nxt);
			end else begin
				lo = nxt - 32'd300 + $urandom_range(0, 3000);
				queue_seg(FUNC_ADD, lo, lo + $urandom_range(1, 700), nxt);
				if ($urandom_range(7) == 0)
					nxt = nxt + $urandom_range(0, 1500);
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_segs.size() != 0 || in_valid || want_beats.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (want_beats.size() != 0)
			note_mismatch($sformatf("%0d beats never arrived", want_beats.size()));

		$display("run: %0d items (%0d clears, %0d bad ranges), %0d list beats checked",
			items_taken, n_clears, n_bad_ranges, beats_seen);
		$display("run: list full after %0d items, one long receiver hold-off of %0d cycles",
			n_full, HOLD_CYCLES);
		if (err_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", err_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### sack_receive_block_list.f
sv/srbl_pkg.sv
sv/srbl_cell.sv
sv/srbl_merge.sv
sv/sack_receive_block_list.sv
bench/tb.sv
